>>> src/ttmf_pkg.sv
// Shared types and constants for the touch trimmed-mean filter.
// Holds the controller state type, the command and status bundles and register indexes.
// No dependencies.
package ttmf_pkg;

  // Width of one ADC sample, one mean and one configuration register.
  localparam int SAMPLE_W = 12;

  // Configuration port index width and register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_FLOOR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGREE_LIMIT = 8'd1;

  // Register values after reset.
  localparam logic [SAMPLE_W-1:0] VALID_FLOOR_RST = 12'd20;
  localparam logic [SAMPLE_W-1:0] AGREE_LIMIT_RST = 12'd50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input word is accepted this cycle
    logic sum_step;  // add the next kept entry to the accumulator
    logic div_step;  // form the mean from the finished sum
    logic decide;    // store the first mean or judge the pair
    logic emit;      // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pen_up;      // the word on the input is a pen release
    logic full;        // the word on the input completes the sample set
    logic sum_last;    // the accumulator is adding its last entry
    logic div_last;    // the mean is ready at the end of this cycle
    logic have_first;  // a first mean of a pair is held
    logic agree;       // the two means lie within the agreement limit
    logic out_free;    // the output register can take a word this cycle
  } status_t;

endpackage

>>> src/touch_trimmed_mean_filter.sv
// Samples that do not complete a set stream at one word a cycle while the controller is idle.
// A pen release is accepted, then its word is loaded into the output register once the output
// is free. A sample that completes a set holds the input while the kept entries are added, one
// a cycle, the mean is formed with one reciprocal multiply and the pair is judged; when a
// coordinate results it holds until its word is loaded, which waits while the output is full.
// Reset is synchronous on rst: collection, pair state and output clear; registers return to 20/50.
module touch_trimmed_mean_filter #(
  parameter int SAMPLES = 8,
  parameter int TRIM    = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               cfg_wen,
  input  logic [ttmf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ttmf_pkg::SAMPLE_W-1:0]      cfg_wdata,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // [11:0] sample, [15:12] zero
  input  logic [1:0]                         s_tuser,   // [0] pen_down, [1] axis
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,   // [11:0] position, [15:12] zero
  output logic [1:0]                         m_tuser    // [0] touched, [1] axis_out
);

  ttmf_pkg::cmd_t    cmd;
  ttmf_pkg::status_t st;
  logic                          out_touched;
  logic                          out_axis;
  logic [ttmf_pkg::SAMPLE_W-1:0] out_position;

  // The controller only sequences; all storage of samples and means is in the datapath.
  ttmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ttmf_dp #(
    .SAMPLES (SAMPLES),
    .TRIM    (TRIM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (s_tdata[ttmf_pkg::SAMPLE_W-1:0]),
    .in_pen_down  (s_tuser[0]),
    .in_axis      (s_tuser[1]),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_touched  (out_touched),
    .out_axis     (out_axis),
    .out_position (out_position)
  );

  assign m_tdata = {4'b0000, out_position};
  assign m_tuser = {out_axis, out_touched};

`ifndef SYNTH
  // The output register is only loaded when its current word is gone or leaving.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over a waiting output word");

  // No new word is taken while a mean is being summed, divided or judged.
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum_step || cmd.div_step || cmd.decide) |-> !s_tready)
    else $error("input accepted during mean computation");

  // A release word carries axis and position zero.
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0 && !m_tuser[1]))
    else $error("release word with nonzero coordinate");

  // An accepted pen release always heads for the output next cycle.
  a_release_emit: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> !s_tready)
    else $error("pen release did not enter the emit step");
`endif

endmodule

>>> src/ttmf_ctrl.sv
// Controller state machine of the touch trimmed-mean filter.
// Sequences accept, accumulate, divide, decide and emit; uses ttmf_pkg.
module ttmf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttmf_pkg::status_t  st,
  output ttmf_pkg::cmd_t     cmd
);

  ttmf_pkg::state_t state;
  ttmf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttmf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ttmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (st.pen_up) begin
            state_next = ttmf_pkg::ST_EMIT;
          end else if (st.full) begin
            state_next = ttmf_pkg::ST_SUM;
          end else begin
            state_next = ttmf_pkg::ST_IDLE;
          end
        end
      end
      ttmf_pkg::ST_SUM: begin
        if (st.sum_last) begin
          state_next = ttmf_pkg::ST_DIV;
        end
      end
      ttmf_pkg::ST_DIV: begin
        if (st.div_last) begin
          state_next = ttmf_pkg::ST_DECIDE;
        end
      end
      ttmf_pkg::ST_DECIDE: begin
        if (st.have_first && st.agree) begin
          state_next = ttmf_pkg::ST_EMIT;
        end else begin
          state_next = ttmf_pkg::ST_IDLE;
        end
      end
      ttmf_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = ttmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ttmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ttmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ttmf_pkg::ST_SUM: begin
        cmd.sum_step = 1'b1;
      end
      ttmf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ttmf_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
      end
      ttmf_pkg::ST_EMIT: begin
        cmd.emit = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> src/ttmf_dp.sv
// Datapath of the touch trimmed-mean filter: insertion-sorted sample chain,
// accumulator, reciprocal multiplier, pair check and output register; uses ttmf_pkg.
module ttmf_dp #(
  parameter int SAMPLES = 8,
  parameter int TRIM    = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [ttmf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [ttmf_pkg::SAMPLE_W-1:0]      cfg_wdata,
  input  logic [ttmf_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                               in_pen_down,
  input  logic                               in_axis,
  input  ttmf_pkg::cmd_t                     cmd,
  output ttmf_pkg::status_t                  st,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_touched,
  output logic                               out_axis,
  output logic [ttmf_pkg::SAMPLE_W-1:0]      out_position
);

  localparam int DW    = ttmf_pkg::SAMPLE_W;
  localparam int CUT   = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
  localparam int NKEEP = SAMPLES - 2 * CUT;
  localparam int FW    = $clog2(SAMPLES + 1);
  localparam int IW    = $clog2(SAMPLES);
  localparam int SW    = IW + DW;
  // The sum always fits in SW bits, so a rounded-up reciprocal of the kept count scaled by
  // 2^(SW + ceil(log2 NKEEP)) gives the exact truncated quotient.
  localparam int LK    = $clog2(NKEEP);
  localparam int RSH   = SW + LK;
  localparam int MW    = SW + 2;
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) << RSH) + longint'(NKEEP) - longint'(1)) / longint'(NKEEP));

  logic [DW-1:0]  valid_floor;
  logic [DW-1:0]  agree_limit;
  logic [DW-1:0]  sorted [SAMPLES];
  logic [FW-1:0]  fill;
  logic [DW-1:0]  first_mean;
  logic           have_first;
  logic           cur_axis;
  logic [SW-1:0]  sum_acc;
  logic [IW-1:0]  k;
  logic [DW-1:0]  quo;
  logic           res_touched;
  logic           res_axis;
  logic [DW-1:0]  res_pos;

  logic           axis_change;
  logic [FW-1:0]  eff_fill;
  logic           keep;
  logic           full;
  logic           gt      [SAMPLES];
  logic           prev_gt [SAMPLES];
  logic [DW-1:0]  prev_val[SAMPLES];
  logic [DW-1:0]  ins     [SAMPLES];
  logic [SW-1:0]  sum_next;
  logic [SW+MW-1:0] prod;
  logic [DW-1:0]  quo_next;
  logic [DW-1:0]  diff;
  logic [DW:0]    pair_sum;

  assign axis_change = (in_axis != cur_axis);
  assign eff_fill    = axis_change ? '0 : fill;
  assign keep        = (in_sample > valid_floor);
  assign full        = keep && (eff_fill == FW'(SAMPLES - 1));

  // Each entry of the chain compares itself with the new sample; the entries
  // above the insertion point move up one place.
  always_comb begin
    for (int j = 0; j < SAMPLES; j++) begin
      gt[j] = (FW'(j) < eff_fill) && (sorted[j] > in_sample);
    end
    prev_gt[0]  = 1'b0;
    prev_val[0] = '0;
    for (int j = 1; j < SAMPLES; j++) begin
      prev_gt[j]  = gt[j-1];
      prev_val[j] = sorted[j-1];
    end
    for (int j = 0; j < SAMPLES; j++) begin
      if (prev_gt[j]) begin
        ins[j] = prev_val[j];
      end else if (gt[j] || (FW'(j) == eff_fill)) begin
        ins[j] = in_sample;
      end else begin
        ins[j] = sorted[j];
      end
    end
  end

  assign sum_next = sum_acc + SW'(sorted[k]);
  assign prod     = (SW+MW)'(sum_acc) * (SW+MW)'(RECIP);
  assign quo_next = prod[RSH +: DW];
  assign diff     = (first_mean > quo) ? (first_mean - quo) : (quo - first_mean);
  assign pair_sum = {1'b0, first_mean} + {1'b0, quo};

  assign st.pen_up     = !in_pen_down;
  assign st.full       = in_pen_down && full;
  assign st.sum_last   = (k == IW'(SAMPLES - CUT - 1));
  assign st.div_last   = 1'b1;
  assign st.have_first = have_first;
  assign st.agree      = (diff <= agree_limit);
  assign st.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_floor <= ttmf_pkg::VALID_FLOOR_RST;
      agree_limit <= ttmf_pkg::AGREE_LIMIT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        ttmf_pkg::REG_VALID_FLOOR: begin
          valid_floor <= cfg_wdata;
        end
        ttmf_pkg::REG_AGREE_LIMIT: begin
          agree_limit <= cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Sample chain; entries at or above the fill count take no part in the insertion compare.
  always_ff @(posedge clk) begin
    if (cmd.take && in_pen_down && keep) begin
      for (int j = 0; j < SAMPLES; j++) begin
        sorted[j] <= ins[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      have_first <= 1'b0;
      cur_axis   <= 1'b0;
      first_mean <= '0;
    end else if (cmd.take) begin
      cur_axis <= in_axis;
      if (!in_pen_down) begin
        fill       <= '0;
        have_first <= 1'b0;
      end else begin
        if (axis_change) begin
          have_first <= 1'b0;
        end
        if (keep) begin
          fill <= full ? '0 : eff_fill + FW'(1);
        end else begin
          fill <= eff_fill;
        end
      end
    end else if (cmd.decide) begin
      if (!have_first) begin
        first_mean <= quo;
        have_first <= 1'b1;
      end else begin
        have_first <= 1'b0;
      end
    end
  end

  // Accumulate the kept entries, then form the mean with one reciprocal multiply.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sum_acc <= '0;
      k       <= IW'(CUT);
    end else if (cmd.sum_step) begin
      sum_acc <= sum_next;
      k       <= k + IW'(1);
    end else if (cmd.div_step) begin
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !in_pen_down) begin
      res_touched <= 1'b0;
      res_axis    <= 1'b0;
      res_pos     <= '0;
    end else if (cmd.decide && have_first) begin
      res_touched <= 1'b1;
      res_axis    <= cur_axis;
      res_pos     <= pair_sum[DW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_touched  <= res_touched;
      out_axis     <= res_axis;
      out_position <= res_pos;
    end
  end

endmodule
